// ----- hw/rtl/asap_pkg.sv -----
package asap_pkg;

  localparam int MAX_SESSIONS   = 3;
  localparam int NONCE_CAPACITY = 64;
  localparam int AUTH_CAPACITY  = 64;

  localparam logic [31:0] AREA_MIN_SIZE = 32'd9;
  localparam logic [15:0] SIZE_OCTETS   = 16'd4;

  // result queue
  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  // parse phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_SIZE      = 3'd1;
  localparam logic [2:0] PH_HANDLE    = 3'd2;
  localparam logic [2:0] PH_NONCE_LEN = 3'd3;
  localparam logic [2:0] PH_NONCE     = 3'd4;
  localparam logic [2:0] PH_ATTR      = 3'd5;
  localparam logic [2:0] PH_AUTH_LEN  = 3'd6;
  localparam logic [2:0] PH_AUTH      = 3'd7;

  // event kinds
  localparam logic [2:0] EV_HANDLE  = 3'd0;
  localparam logic [2:0] EV_NONCE   = 3'd1;
  localparam logic [2:0] EV_ATTR    = 3'd2;
  localparam logic [2:0] EV_AUTH    = 3'd3;
  localparam logic [2:0] EV_SESSION = 3'd4;
  localparam logic [2:0] EV_AREA    = 3'd5;
  localparam logic [2:0] EV_ERROR   = 3'd6;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_INSUFF   = 2'd1;
  localparam logic [1:0] ERR_AUTHSIZE = 2'd2;
  localparam logic [1:0] ERR_SIZE     = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  session;
    logic [31:0] value;
    logic [5:0]  offset;
    logic [1:0]  err;
    logic        last;
  } evt_t;

  typedef struct packed {
    logic [1:0]                   count;
    evt_t [MAX_RESULTS-1:0]       ev;
  } push_t;

  function automatic evt_t mk_evt(input logic [2:0] kind, input logic [1:0] session,
                                  input logic [31:0] value, input logic [5:0] offset,
                                  input logic [1:0] err, input logic last);
    evt_t e;
    e.kind    = kind;
    e.session = session;
    e.value   = value;
    e.offset  = offset;
    e.err     = err;
    e.last    = last;
    return e;
  endfunction

endpackage

// ----- hw/rtl/asap_in_if.sv -----
interface asap_in_if;
  logic        valid;
  logic        ready;
  logic        area_start;
  logic [7:0]  data_octet;
  logic [15:0] available_length;

  modport source (output valid, output area_start, output data_octet,
                  output available_length, input ready);
  modport sink (input valid, input area_start, input data_octet,
                input available_length, output ready);
endinterface

// ----- hw/rtl/asap_out_if.sv -----
interface asap_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [1:0]  session_number;
  logic [31:0] field_value;
  logic [5:0]  octet_offset;
  logic [1:0]  error_code;
  logic        area_last;

  modport source (output valid, output event_kind, output session_number,
                  output field_value, output octet_offset, output error_code,
                  output area_last, input ready);
  modport sink (input valid, input event_kind, input session_number,
                input field_value, input octet_offset, input error_code,
                input area_last, output ready);
endinterface

// ----- hw/rtl/asap_core.sv -----
module asap_core
  import asap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        area_start,
  input  logic [7:0]  data_octet,
  input  logic [15:0] available_length,
  output push_t       push
);

  logic [2:0]  phase, phase_next;
  logic [15:0] position, position_next;
  logic [15:0] area_end, area_end_next;
  logic [15:0] avail_total, avail_total_next;
  logic [31:0] field_shift, field_shift_next;
  logic [6:0]  octets_left, octets_left_next;
  logic [1:0]  session_count, session_count_next;

  logic [1:0]  n;
  evt_t [MAX_RESULTS-1:0] res;
  logic [1:0]  num;
  logic        go;
  logic        fin_req;
  logic        bs_req;
  logic        bf_req;
  logic [2:0]  bf_phase;
  logic [2:0]  bf_len;
  logic [15:0] len;
  logic        is_nonce;

  always_comb begin
    phase_next         = phase;
    position_next      = position;
    area_end_next      = area_end;
    avail_total_next   = avail_total;
    field_shift_next   = field_shift;
    octets_left_next   = octets_left;
    session_count_next = session_count;
    n        = 2'd0;
    res      = '0;
    num      = 2'(session_count + 2'd1);
    go       = 1'b1;
    fin_req  = 1'b0;
    bs_req   = 1'b0;
    bf_req   = 1'b0;
    bf_phase = PH_IDLE;
    bf_len   = 3'd0;
    len      = field_shift[15:0];
    is_nonce = 1'b0;

    if (area_start) begin
      avail_total_next   = available_length;
      position_next      = '0;
      area_end_next      = '0;
      session_count_next = '0;
      field_shift_next   = '0;
      octets_left_next   = 7'(SIZE_OCTETS);
      if (available_length < SIZE_OCTETS) begin
        phase_next = PH_IDLE;
        res[n] = mk_evt(EV_ERROR, 2'd0, '0, '0, ERR_INSUFF, 1'b1);
        n = n + 2'd1;
        go = 1'b0;
      end else begin
        phase_next = PH_SIZE;
        num = 2'd1;
      end
    end
    if (phase_next == PH_IDLE) go = 1'b0;

    if (go) begin
      position_next = 16'(position_next + 16'd1);
      case (phase_next)
        PH_SIZE: begin
          field_shift_next = {field_shift_next[23:0], data_octet};
          octets_left_next = 7'(octets_left_next - 7'd1);
          if (octets_left_next == '0) begin
            if (field_shift_next < AREA_MIN_SIZE ||
                field_shift_next > {16'd0, 16'(avail_total_next - SIZE_OCTETS)}) begin
              phase_next = PH_IDLE;
              res[n] = mk_evt(EV_ERROR, 2'd0, '0, '0, ERR_AUTHSIZE, 1'b1);
              n = n + 2'd1;
            end else begin
              area_end_next = 16'(SIZE_OCTETS + field_shift_next[15:0]);
              bs_req = 1'b1;
            end
          end
        end
        PH_HANDLE: begin
          field_shift_next = {field_shift_next[23:0], data_octet};
          octets_left_next = 7'(octets_left_next - 7'd1);
          if (octets_left_next == '0) begin
            res[n] = mk_evt(EV_HANDLE, num, field_shift_next, '0, ERR_NONE, 1'b0);
            n = n + 2'd1;
            bf_req   = 1'b1;
            bf_phase = PH_NONCE_LEN;
            bf_len   = 3'd2;
          end
        end
        PH_NONCE_LEN, PH_AUTH_LEN: begin
          is_nonce = (phase_next == PH_NONCE_LEN);
          field_shift_next = {16'd0, field_shift_next[7:0], data_octet};
          octets_left_next = 7'(octets_left_next - 7'd1);
          len = field_shift_next[15:0];
          if (octets_left_next == '0) begin
            if (len > (is_nonce ? 16'(NONCE_CAPACITY) : 16'(AUTH_CAPACITY))) begin
              phase_next = PH_IDLE;
              res[n] = mk_evt(EV_ERROR, num, '0, '0, ERR_SIZE, 1'b1);
              n = n + 2'd1;
            end else if ({1'b0, position_next} + {1'b0, len} > {1'b0, area_end_next}) begin
              phase_next = PH_IDLE;
              res[n] = mk_evt(EV_ERROR, num, '0, '0, ERR_INSUFF, 1'b1);
              n = n + 2'd1;
            end else if (len == '0) begin
              if (is_nonce) begin
                bf_req   = 1'b1;
                bf_phase = PH_ATTR;
                bf_len   = 3'd1;
              end else begin
                fin_req = 1'b1;
              end
            end else begin
              phase_next       = is_nonce ? PH_NONCE : PH_AUTH;
              octets_left_next = len[6:0];
              field_shift_next = '0;
            end
          end
        end
        PH_NONCE, PH_AUTH: begin
          is_nonce = (phase_next == PH_NONCE);
          res[n] = mk_evt(is_nonce ? EV_NONCE : EV_AUTH, num, {24'd0, data_octet},
                          field_shift_next[5:0], ERR_NONE, 1'b0);
          n = n + 2'd1;
          field_shift_next = 32'(field_shift_next + 32'd1);
          octets_left_next = 7'(octets_left_next - 7'd1);
          if (octets_left_next == '0) begin
            if (is_nonce) begin
              bf_req   = 1'b1;
              bf_phase = PH_ATTR;
              bf_len   = 3'd1;
            end else begin
              fin_req = 1'b1;
            end
          end
        end
        PH_ATTR: begin
          res[n] = mk_evt(EV_ATTR, num, {24'd0, data_octet}, '0, ERR_NONE, 1'b0);
          n = n + 2'd1;
          bf_req   = 1'b1;
          bf_phase = PH_AUTH_LEN;
          bf_len   = 3'd2;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      // close the session, then either end the area, open the next session or flag an error
      if (fin_req) begin
        session_count_next = 2'(session_count_next + 2'd1);
        res[n] = mk_evt(EV_SESSION, session_count_next, {30'd0, session_count_next}, '0,
                        ERR_NONE, 1'b0);
        n = n + 2'd1;
        if (position_next == area_end_next) begin
          phase_next = PH_IDLE;
          res[n] = mk_evt(EV_AREA, 2'd0, {16'd0, area_end_next}, '0, ERR_NONE, 1'b1);
          n = n + 2'd1;
        end else begin
          bs_req = 1'b1;
        end
      end
      if (bs_req) begin
        if (session_count_next >= 2'(MAX_SESSIONS)) begin
          phase_next = PH_IDLE;
          res[n] = mk_evt(EV_ERROR, 2'd0, '0, '0, ERR_AUTHSIZE, 1'b1);
          n = n + 2'd1;
        end else begin
          bf_req   = 1'b1;
          bf_phase = PH_HANDLE;
          bf_len   = 3'd4;
        end
      end
      if (bf_req) begin
        if ({1'b0, position_next} + 17'(bf_len) > {1'b0, area_end_next}) begin
          phase_next = PH_IDLE;
          res[n] = mk_evt(EV_ERROR, 2'(session_count_next + 2'd1), '0, '0,
                          ERR_INSUFF, 1'b1);
          n = n + 2'd1;
        end else begin
          phase_next       = bf_phase;
          octets_left_next = 7'(bf_len);
          field_shift_next = '0;
        end
      end
    end
  end

  assign push.count = accept ? n : 2'd0;
  assign push.ev    = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      position      <= '0;
      area_end      <= '0;
      avail_total   <= '0;
      field_shift   <= '0;
      octets_left   <= '0;
      session_count <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      position      <= position_next;
      area_end      <= area_end_next;
      avail_total   <= avail_total_next;
      field_shift   <= field_shift_next;
      octets_left   <= octets_left_next;
      session_count <= session_count_next;
    end
  end

endmodule

// ----- hw/rtl/asap_fifo.sv -----
module asap_fifo
  import asap_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  push_t         push,
  output logic          room,
  asap_out_if.source    events
);

  evt_t                mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr;
  logic [FIFO_AW-1:0]  rd_ptr;
  logic [FIFO_AW:0]    count;
  logic                pop;
  evt_t                head;

  assign pop  = events.valid && events.ready;
  assign room = (count <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RESULTS));
  assign head = mem[rd_ptr];

  assign events.valid          = (count != '0);
  assign events.event_kind     = head.kind;
  assign events.session_number = head.session;
  assign events.field_value    = head.value;
  assign events.octet_offset   = head.offset;
  assign events.error_code     = head.err;
  assign events.area_last      = head.last;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < push.count) begin
        mem[FIFO_AW'(wr_ptr + FIFO_AW'(i))] <= push.ev[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= FIFO_AW'(wr_ptr + FIFO_AW'(push.count));
      if (pop) rd_ptr <= FIFO_AW'(rd_ptr + 1'b1);
      count  <= (FIFO_AW+1)'(count + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop));
    end
  end

endmodule

// ----- hw/rtl/auth_session_area_parser.sv -----
// Authorization area parser.
// octets: one command octet per beat; area_start flags the first octet of an
//   area and carries available_length, the octets available from there on.
// events: one parse event per beat (handle, nonce octet, attributes, auth
//   octet, session done, area done, error); area_last marks the final event.
// One octet is taken per cycle while the queue has room. Each octet yields zero
// to three events, which go into an eight-entry result queue; an octet's events
// are written into the queue registers before they reach the events channel.
// Sustained rate is one octet per cycle while the receiver takes one event
// per cycle; octets that end a session produce one to three events, so the
// queue drain rate of one event per cycle sets the long-run limit.
// ready on octets drops whenever fewer than three queue entries are free, so
// a stalled receiver backs up into the sender without losing events.
// Reset empties the queue and returns the parser to idle: octets are then
// ignored until one with area_start set arrives.
module auth_session_area_parser
  import asap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  asap_in_if.sink     octets,
  asap_out_if.source  events
);

  logic  room;
  logic  accept;
  push_t push;

  assign octets.ready = room;
  assign accept       = octets.valid && room;

  asap_core u_core (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .area_start       (octets.area_start),
    .data_octet       (octets.data_octet),
    .available_length (octets.available_length),
    .push             (push)
  );

  asap_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .events (events)
  );

endmodule
